@@ sv/astar_open_list_insert_unit_defines.svh @@
// assertion macros shared by the open list rtl
`ifndef ASTAR_OPEN_LIST_INSERT_UNIT_DEFINES_SVH
`define ASTAR_OPEN_LIST_INSERT_UNIT_DEFINES_SVH

// same-cycle implication
`define AOLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AOLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/aoli_pkg.sv @@
package aoli_pkg;

  localparam int ID_W    = 20;
  localparam int COORD_W = 10;
  localparam int COST_W  = 20;
  localparam int RES_W   = 8;
  localparam int H_W     = 11;
  localparam int PLACE_W = 3;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic REQ_OPEN = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  localparam logic REG_TARGET_X = 1'b0;
  localparam logic REG_TARGET_Y = 1'b1;

  typedef enum logic [PLACE_W-1:0] {
    PLACE_FRONT  = 3'd0,
    PLACE_BACK   = 3'd1,
    PLACE_LARGER = 3'd2,
    PLACE_TIE    = 3'd3,
    PLACE_FULL   = 3'd4
  } place_t;

  typedef struct packed {
    logic               req_type;
    logic [ID_W-1:0]    node_id;
    logic [COORD_W-1:0] node_x;
    logic [COORD_W-1:0] node_y;
    logic [COST_W-1:0]  parent_cost;
    logic [RES_W-1:0]   resistance;
  } in_item_t;

  typedef struct packed {
    logic              reached_target;
    logic [COST_W-1:0] path_cost;
    logic [COST_W-1:0] total_cost;
    place_t            place;
    logic [ID_W-1:0]   best_id;
    logic              best_valid;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [COST_W-1:0] f;
    logic [H_W-1:0]    h;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_STEP,
    CMD_COMMIT,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    logic act;
    logic vld;
    logic f_gt;
    logic f_eq;
    logic h_ge;
  } cell_rpt_t;

endpackage

@@ sv/aoli_cost.sv @@
module aoli_cost (
  input  logic                         clk,
  input  logic [aoli_pkg::COORD_W-1:0] node_x,
  input  logic [aoli_pkg::COORD_W-1:0] node_y,
  input  logic [aoli_pkg::COST_W-1:0]  parent_cost,
  input  logic [aoli_pkg::RES_W-1:0]   resistance,
  input  logic [aoli_pkg::COORD_W-1:0] target_x,
  input  logic [aoli_pkg::COORD_W-1:0] target_y,
  output logic [aoli_pkg::COST_W-1:0]  g,
  output logic [aoli_pkg::H_W-1:0]     h,
  output logic [aoli_pkg::COST_W-1:0]  f,
  output logic                         at_target
);
  import aoli_pkg::*;

  logic [COST_W:0]    g_sum;
  logic [COST_W:0]    f_sum;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [COST_W-1:0]  g_r;
  logic [H_W-1:0]     h_r;
  logic [COST_W-1:0]  f_r;
  logic               at_target_r;

  // stage one: g and manhattan distance
  always_comb begin
    g_sum = {1'b0, parent_cost} + {{(COST_W + 1 - RES_W){1'b0}}, resistance};
    dx    = (node_x > target_x) ? node_x - target_x : target_x - node_x;
    dy    = (node_y > target_y) ? node_y - target_y : target_y - node_y;
  end

  // stage two: f
  assign f_sum = {1'b0, g_r} + {{(COST_W + 1 - H_W){1'b0}}, h_r};

  always_ff @(posedge clk) begin
    g_r         <= g_sum[COST_W] ? COST_MAX : g_sum[COST_W-1:0];
    h_r         <= {1'b0, dx} + {1'b0, dy};
    at_target_r <= (node_x == target_x) && (node_y == target_y);
    f_r         <= f_sum[COST_W] ? COST_MAX : f_sum[COST_W-1:0];
  end

  assign g         = g_r;
  assign h         = h_r;
  assign f         = f_r;
  assign at_target = at_target_r;

endmodule

@@ sv/aoli_cell.sv @@
module aoli_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  aoli_pkg::cell_cmd_t cmd,
  input  aoli_pkg::entry_t    new_ent,
  input  aoli_pkg::entry_t    left_ent,
  input  logic                left_vld,
  input  logic                left_seen,
  input  aoli_pkg::entry_t    right_ent,
  input  logic                right_vld,
  output aoli_pkg::entry_t    ent,
  output logic                vld,
  output logic                seen,
  output aoli_pkg::cell_rpt_t rpt
);
  import aoli_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   vld_r;
  logic   vld_nxt;
  logic   seen_r;
  logic   seen_nxt;
  logic   act;

  // the search token sits here when the left neighbor was passed and this cell was not
  assign act = left_seen & ~seen_r;

  always_comb begin
    ent_nxt  = ent_r;
    vld_nxt  = vld_r;
    seen_nxt = seen_r;
    unique case (cmd)
      CMD_HOLD: begin
      end
      CMD_STEP: begin
        if (act) begin
          seen_nxt = 1'b1;
        end
      end
      CMD_COMMIT: begin
        seen_nxt = 1'b0;
        if (act) begin
          ent_nxt = new_ent;
          vld_nxt = 1'b1;
        end else if (!seen_r) begin
          ent_nxt = left_ent;
          vld_nxt = left_vld;
        end
      end
      CMD_POP: begin
        ent_nxt = right_ent;
        vld_nxt = right_vld;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_comb begin
    rpt.act  = act;
    rpt.vld  = vld_r;
    rpt.f_gt = ent_r.f > new_ent.f;
    rpt.f_eq = ent_r.f == new_ent.f;
    rpt.h_ge = ent_r.h >= new_ent.h;
  end

  assign ent  = ent_r;
  assign vld  = vld_r;
  assign seen = seen_r;

endmodule

@@ sv/astar_open_list_insert_unit.sv @@
// channel  | dir | handshake           | payload
// ---------+-----+---------------------+------------------------------
// in       | in  | in_valid / in_stall | in_data   (aoli_pkg::in_item_t)
// out      | out | out_valid/out_stall | out_data  (aoli_pkg::out_item_t)
// cfg      | in  | cfg_we              | cfg_index, cfg_wdata
//
// one request at a time; in_stall is low only while idle
// take: accept, pop, load output
// open to the target or into a full list: accept, cost, total, decide, load output
// insert at list position p: the search token walks the cell chain from the front to cell p, then the output loads
// reset (synchronous, rst_n low) empties the list; no clearing pass
// a stalled output holds the block in its output state; the result register decouples it
`include "astar_open_list_insert_unit_defines.svh"

module astar_open_list_insert_unit #(
  parameter int OPEN_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  aoli_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output aoli_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [aoli_pkg::COORD_W-1:0] cfg_wdata
);
  import aoli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COST,
    S_TOTAL,
    S_DECIDE,
    S_SEARCH,
    S_OUT
  } state_t;

  state_t    state_r;
  in_item_t  req_r;
  out_item_t res_r;
  out_item_t out_data_r;
  logic      out_valid_r;

  logic [COORD_W-1:0] target_x_r;
  logic [COORD_W-1:0] target_y_r;

  logic [COST_W-1:0] g_cost;
  logic [H_W-1:0]    h_cost;
  logic [COST_W-1:0] f_cost;
  logic              at_target;

  cell_cmd_t cell_cmd;
  entry_t    new_ent;
  entry_t    cell_ent  [OPEN_DEPTH];
  cell_rpt_t cell_rpt  [OPEN_DEPTH];
  place_t    cell_code [OPEN_DEPTH];
  logic [OPEN_DEPTH-1:0] cell_vld;
  logic [OPEN_DEPTH-1:0] cell_seen;
  logic [OPEN_DEPTH-1:0] hit_vec;
  logic [PLACE_W-1:0]    found_place;
  int                    list_fill;

  // configuration registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r <= '0;
      target_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X: target_x_r <= cfg_wdata;
        REG_TARGET_Y: target_y_r <= cfg_wdata;
      endcase
    end
  end

  // two-stage cost pipe, fed from the held request
  aoli_cost u_cost (
    .clk         (clk),
    .node_x      (req_r.node_x),
    .node_y      (req_r.node_y),
    .parent_cost (req_r.parent_cost),
    .resistance  (req_r.resistance),
    .target_x    (target_x_r),
    .target_y    (target_y_r),
    .g           (g_cost),
    .h           (h_cost),
    .f           (f_cost),
    .at_target   (at_target)
  );

  assign new_ent = '{id: req_r.node_id, f: f_cost, h: h_cost};

  // cell chain: cell 0 is the front (best f)
  for (genvar i = 0; i < OPEN_DEPTH; i++) begin : g_cell
    entry_t l_ent;
    entry_t r_ent;
    logic   l_vld;
    logic   l_seen;
    logic   r_vld;

    if (i == 0) begin : g_head
      assign l_ent  = '0;
      assign l_vld  = 1'b0;
      assign l_seen = 1'b1;
      // front rule: equal f also goes first
      assign hit_vec[i] = cell_rpt[i].act &
                          (~cell_rpt[i].vld | cell_rpt[i].f_gt | cell_rpt[i].f_eq);
    end else begin : g_body
      assign l_ent  = cell_ent[i-1];
      assign l_vld  = cell_vld[i-1];
      assign l_seen = cell_seen[i-1];
      // middle rule: larger f, or equal f with greater-or-equal h
      assign hit_vec[i] = cell_rpt[i].act &
                          (~cell_rpt[i].vld | cell_rpt[i].f_gt |
                           (cell_rpt[i].f_eq & cell_rpt[i].h_ge));
    end

    if (i == OPEN_DEPTH - 1) begin : g_tail
      assign r_ent = '0;
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_ent = cell_ent[i+1];
      assign r_vld = cell_vld[i+1];
    end

    // placement code this cell would report if it takes the entry
    always_comb begin
      if (i == 0) begin
        cell_code[i] = PLACE_FRONT;
      end else if (!cell_rpt[i].vld) begin
        cell_code[i] = PLACE_BACK;
      end else if (cell_rpt[i].f_gt) begin
        cell_code[i] = PLACE_LARGER;
      end else begin
        cell_code[i] = PLACE_TIE;
      end
    end

    aoli_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cell_cmd),
      .new_ent   (new_ent),
      .left_ent  (l_ent),
      .left_vld  (l_vld),
      .left_seen (l_seen),
      .right_ent (r_ent),
      .right_vld (r_vld),
      .ent       (cell_ent[i]),
      .vld       (cell_vld[i]),
      .seen      (cell_seen[i]),
      .rpt       (cell_rpt[i])
    );
  end

  // only the token cell can hit, so an or over the chain picks its code
  always_comb begin
    found_place = '0;
    for (int i = 0; i < OPEN_DEPTH; i++) begin
      found_place = found_place | (hit_vec[i] ? cell_code[i] : '0);
    end
  end

  // chain command
  always_comb begin
    cell_cmd = CMD_HOLD;
    if (state_r == S_COST && req_r.req_type == REQ_TAKE) begin
      cell_cmd = CMD_POP;
    end else if (state_r == S_SEARCH) begin
      cell_cmd = (|hit_vec) ? CMD_COMMIT : CMD_STEP;
    end
  end

  // request sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output register: loads from the result, drains when the receiver takes it
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_COST;
          end
        end
        S_COST: begin
          if (req_r.req_type == REQ_TAKE) begin
            // pop happens at this edge; report the old front
            res_r   <= '{reached_target: 1'b0, path_cost: '0, total_cost: '0,
                         place: PLACE_FRONT,
                         best_id: (cell_vld[0] ? cell_ent[0].id : '0),
                         best_valid: cell_vld[0]};
            state_r <= S_OUT;
          end else begin
            state_r <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (at_target) begin
            // nothing inserted, h is zero on the target
            res_r   <= '{reached_target: 1'b1, path_cost: g_cost, total_cost: g_cost,
                         place: PLACE_FRONT, best_id: '0, best_valid: 1'b0};
            state_r <= S_OUT;
          end else if (cell_vld[OPEN_DEPTH-1]) begin
            res_r   <= '{reached_target: 1'b0, path_cost: g_cost, total_cost: f_cost,
                         place: PLACE_FULL, best_id: '0, best_valid: 1'b0};
            state_r <= S_OUT;
          end else begin
            // place is filled in when the search hits
            res_r   <= '{reached_target: 1'b0, path_cost: g_cost, total_cost: f_cost,
                         place: PLACE_FRONT, best_id: '0, best_valid: 1'b0};
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (|hit_vec) begin
            res_r.place <= place_t'(found_place);
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign list_fill = $countones(cell_vld);

  `AOLI_ASSERT_IMP(a_single_hit, clk, rst_n, 1'b1, $onehot0(hit_vec), "more than one cell hit")
  `AOLI_ASSERT_IMP(a_vld_packed, clk, rst_n, 1'b1, ((cell_vld >> 1) & ~cell_vld) == '0, "gap")
  `AOLI_ASSERT_IMP(a_seen_packed, clk, rst_n, 1'b1, ((cell_seen >> 1) & ~cell_seen) == '0, "gap")
  `AOLI_ASSERT_IMP(a_search_room, clk, rst_n, state_r == S_SEARCH, !cell_vld[OPEN_DEPTH-1], "full")
  `AOLI_ASSERT_NXT(a_commit_grows, clk, rst_n, cell_cmd == CMD_COMMIT, list_fill == $past(list_fill) + 1, "lost")
  `AOLI_ASSERT_NXT(a_pop_shrinks, clk, rst_n, cell_cmd == CMD_POP && cell_vld[0], list_fill + 1 == $past(list_fill), "lost")

endmodule
